// ===== src/kgemb_pkg.sv =====
// ----------------------------------------------------------------------------
// kgemb_pkg
// Shared widths, codes and reset values of the embedding store and trainer.
// ----------------------------------------------------------------------------
package kgemb_pkg;

    localparam int DIM           = 128;
    localparam int NUM_ENTITIES  = 1024;
    localparam int NUM_RELATIONS = 64;

    localparam int EL_W      = $clog2(DIM);
    localparam int ENT_ROW_W = $clog2(NUM_ENTITIES);
    localparam int REL_ROW_W = $clog2(NUM_RELATIONS);
    localparam int ENT_ADDR_W = ENT_ROW_W + EL_W;
    localparam int REL_ADDR_W = REL_ROW_W + EL_W;
    localparam int ENT_DEPTH  = NUM_ENTITIES * DIM;
    localparam int REL_DEPTH  = NUM_RELATIONS * DIM;

    localparam logic [12:0] ONE_Q12 = 13'd4096;

    // Operation codes carried in the input item.
    localparam logic [1:0] FUNC_WR_ENT = 2'd0;
    localparam logic [1:0] FUNC_WR_REL = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_TRAIN  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] REG_LOSS_MARGIN   = 2'd1;
    localparam logic [1:0] REG_DIM_IN_USE    = 2'd2;

    localparam logic [11:0] LR_RESET     = 12'd4;
    localparam logic [14:0] MARGIN_RESET = 15'd4096;
    localparam logic [7:0]  DIM_RESET    = 8'd100;

endpackage

// ===== src/kgemb_ram.sv =====
// ----------------------------------------------------------------------------
// kgemb_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module kgemb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/kg_embedding_margin_sgd_step.sv =====
// ----------------------------------------------------------------------------
// kg_embedding_margin_sgd_step
// Embedding store with a TransE style margin training step and renormalization.
// ----------------------------------------------------------------------------
// Usage: one item enters on the s_ channel (tuser holds func and read_relation,
// tdata the indexes and write value). Each item produces exactly one result
// item on the m_ channel. Entity and relation vectors live in two single-port
// RAMs with a registered read port; a sequencer walks them one element at
// a time. The user must write the registers over the APB port only while the
// block is idle; the block itself does not enforce it. A training step first
// sums the two distances, then updates every element when the margin is
// violated, then for each of the five rows computes the norm and, when that
// row is renormalized, runs the 16-step shift-subtract divider on every
// element. Each table has a single RAM port, and the square root and the
// divider are serial.
// One item is handled at a time. The result sits in an output register; the
// block takes the next item while it waits, and only blocks at the end of
// that next item if the receiver still stalls. Reset restores the register
// defaults and clears the control state; table contents stay undefined until
// written.
// ----------------------------------------------------------------------------
module kg_embedding_margin_sgd_step (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, low to high: head_index[9:0], tail_index[19:10],
    // relation_index[25:20], neg_head_index[35:26], neg_tail_index[45:36],
    // element_index[52:46], write_value[68:53], zero fill[71:69]
    input  logic [71:0] s_tdata,
    // tuser, low to high: func[1:0], read_relation[2]
    input  logic [2:0]  s_tuser,
    // Result item channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata, low to high: read_value[15:0], pos_distance[39:16],
    // neg_distance[63:40], step_loss[88:64], updated[89], zero fill[95:90]
    output logic [95:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW = kgemb_pkg::EL_W;
    localparam int HW = kgemb_pkg::ENT_ROW_W;
    localparam int RW = kgemb_pkg::REL_ROW_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_RDW   = 5'd2;
    localparam logic [4:0] S_GATH  = 5'd3;
    localparam logic [4:0] S_DIST  = 5'd4;
    localparam logic [4:0] S_CHECK = 5'd5;
    localparam logic [4:0] S_UR    = 5'd6;
    localparam logic [4:0] S_UH    = 5'd7;
    localparam logic [4:0] S_UT    = 5'd8;
    localparam logic [4:0] S_UR2   = 5'd9;
    localparam logic [4:0] S_UNH   = 5'd10;
    localparam logic [4:0] S_UNT   = 5'd11;
    localparam logic [4:0] S_NRD   = 5'd12;
    localparam logic [4:0] S_NSQ   = 5'd13;
    localparam logic [4:0] S_SQRT  = 5'd14;
    localparam logic [4:0] S_SRD   = 5'd15;
    localparam logic [4:0] S_SCAP  = 5'd16;
    localparam logic [4:0] S_DIV   = 5'd17;
    localparam logic [4:0] S_SWR   = 5'd18;
    localparam logic [4:0] S_NNEXT = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    // Configuration registers.
    logic [11:0] lr_reg;
    logic [14:0] margin_reg;
    logic [7:0]  dim_reg;

    // Latched input item.
    logic [1:0]         func_reg;
    logic [HW-1:0]      h_reg, t_reg, nh_reg, nt_reg;
    logic [RW-1:0]      r_reg;
    logic [EW-1:0]      el_in_reg;
    logic               rdrel_reg;
    logic signed [15:0] wv_reg;

    // Sequencer.
    logic [4:0]    state_reg;
    logic [EW-1:0] el_reg;
    logic [2:0]    sub_reg;
    logic          mode_reg;
    logic          sign_reg;
    logic [2:0]    nrow_reg;
    logic [4:0]    cnt_reg;

    // Element values of the five rows at the current element.
    logic signed [15:0] vh_reg, vt_reg, vnh_reg, vnt_reg, vr_reg;

    // Results being built.
    logic [15:0] rv_reg;
    logic [23:0] pos_reg, neg_reg;
    logic [24:0] loss_reg;
    logic        upd_reg;

    // Norm, square root and divider.
    logic [37:0] sumsq_reg;
    logic [20:0] sqrem_reg;
    logic [18:0] root_reg;
    logic [19:0] drem_reg;
    logic [15:0] dq_reg;
    logic        dneg_reg;

    // Output register.
    logic        out_valid_reg;
    logic [95:0] out_data_reg;

    // RAM ports.
    logic                               ent_we, rel_we;
    logic [kgemb_pkg::ENT_ADDR_W-1:0]   ent_addr;
    logic [kgemb_pkg::REL_ADDR_W-1:0]   rel_addr;
    logic [15:0]                        ent_wdata, rel_wdata, ent_rdata, rel_rdata;

    kgemb_ram #(.WIDTH(16), .DEPTH(kgemb_pkg::ENT_DEPTH)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (ent_wdata),
        .rdata (ent_rdata)
    );

    kgemb_ram #(.WIDTH(16), .DEPTH(kgemb_pkg::REL_DEPTH)) u_rel_ram (
        .aclk  (aclk),
        .we    (rel_we),
        .addr  (rel_addr),
        .wdata (rel_wdata),
        .rdata (rel_rdata)
    );

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    // Active dimension: zero acts as one, anything above DIM acts as DIM.
    logic [7:0] ndim;
    logic       last_el;
    always_comb begin
        if (dim_reg == 8'd0) begin
            ndim = 8'd1;
        end else if (dim_reg > 8'(kgemb_pkg::DIM)) begin
            ndim = 8'(kgemb_pkg::DIM);
        end else begin
            ndim = dim_reg;
        end
    end
    assign last_el = ({1'b0, el_reg} == ndim - 8'd1);

    // Element differences of both triples from the current values.
    logic signed [17:0] x1, x2;
    logic [16:0]        ax1, ax2;
    assign x1  = 18'(vt_reg) - 18'(vh_reg) - 18'(vr_reg);
    assign x2  = 18'(vnt_reg) - 18'(vnh_reg) - 18'(vr_reg);
    assign ax1 = x1[17] ? 17'(-x1) : 17'(x1);
    assign ax2 = x2[17] ? 17'(-x2) : 17'(x2);

    // Sign step on one element: operand plus or minus alpha, saturated.
    logic signed [15:0] upd_op;
    logic               upd_add;
    logic signed [15:0] upd_nv;
    logic [HW-1:0]      upd_row;
    always_comb begin
        upd_op  = vr_reg;
        upd_add = 1'b0;
        upd_row = h_reg;
        unique case (state_reg)
            S_UR:  begin upd_op = vr_reg;  upd_add = (x1 > 18'sd0);  end
            S_UH:  begin upd_op = vh_reg;  upd_add = sign_reg;  upd_row = h_reg; end
            S_UT:  begin upd_op = vt_reg;  upd_add = !sign_reg; upd_row = t_reg; end
            S_UR2: begin upd_op = vr_reg;  upd_add = !(x2 > 18'sd0); end
            S_UNH: begin upd_op = vnh_reg; upd_add = !sign_reg; upd_row = nh_reg; end
            S_UNT: begin upd_op = vnt_reg; upd_add = sign_reg;  upd_row = nt_reg; end
            default: begin upd_op = vr_reg; end
        endcase
    end
    assign upd_nv = sat16(upd_add ? 18'(upd_op) + 18'(lr_reg) : 18'(upd_op) - 18'(lr_reg));

    // Row being normalized: the relation first, then the four entities.
    logic          n_is_rel;
    logic [HW-1:0] n_ent_row;
    logic [15:0]   n_data;
    assign n_is_rel = (nrow_reg == 3'd0);
    always_comb begin
        unique case (nrow_reg)
            3'd1:    n_ent_row = h_reg;
            3'd2:    n_ent_row = t_reg;
            3'd3:    n_ent_row = nh_reg;
            default: n_ent_row = nt_reg;
        endcase
    end
    assign n_data = n_is_rel ? rel_rdata : ent_rdata;

    logic signed [31:0] n_sq;
    assign n_sq = $signed(n_data) * $signed(n_data);

    // Square root step: two bits of the sum of squares per cycle.
    logic [20:0] sq_shift, sq_trial;
    assign sq_shift = {sqrem_reg[18:0], sumsq_reg[37:36]};
    assign sq_trial = {root_reg[18:0], 2'b01};

    // Divider step: one quotient bit per cycle.
    logic [19:0] div_shift;
    assign div_shift = {drem_reg[18:0], dq_reg[15]};

    logic [15:0] n_mag;
    assign n_mag = n_data[15] ? 16'(-$signed(n_data)) : n_data;

    // Comparison of the hinge against the negative distance.
    logic [24:0] pm;
    assign pm = 25'(pos_reg) + 25'(margin_reg);

    // RAM address and write control.
    always_comb begin
        ent_we    = 1'b0;
        rel_we    = 1'b0;
        ent_addr  = {h_reg, el_reg};
        rel_addr  = {r_reg, el_reg};
        ent_wdata = upd_nv;
        rel_wdata = upd_nv;
        unique case (state_reg)
            S_DISP: begin
                ent_addr  = {h_reg, el_in_reg};
                rel_addr  = {r_reg, el_in_reg};
                ent_wdata = wv_reg;
                rel_wdata = wv_reg;
                ent_we    = (func_reg == kgemb_pkg::FUNC_WR_ENT);
                rel_we    = (func_reg == kgemb_pkg::FUNC_WR_REL);
            end
            S_GATH: begin
                unique case (sub_reg)
                    3'd1:    ent_addr = {t_reg, el_reg};
                    3'd2:    ent_addr = {nh_reg, el_reg};
                    3'd3:    ent_addr = {nt_reg, el_reg};
                    default: ent_addr = {h_reg, el_reg};
                endcase
            end
            S_UR, S_UR2: begin
                rel_we = 1'b1;
            end
            S_UH, S_UT, S_UNH, S_UNT: begin
                ent_we   = 1'b1;
                ent_addr = {upd_row, el_reg};
            end
            S_NRD, S_SRD: begin
                ent_addr = {n_ent_row, el_reg};
            end
            S_SWR: begin
                ent_addr  = {n_ent_row, el_reg};
                ent_wdata = dneg_reg ? 16'(-$signed(dq_reg)) : dq_reg;
                rel_wdata = ent_wdata;
                ent_we    = !n_is_rel;
                rel_we    = n_is_rel;
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            kgemb_pkg::REG_LEARNING_RATE: prdata = {20'd0, lr_reg};
            kgemb_pkg::REG_LOSS_MARGIN:   prdata = {17'd0, margin_reg};
            kgemb_pkg::REG_DIM_IN_USE:    prdata = {24'd0, dim_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg     <= kgemb_pkg::LR_RESET;
            margin_reg <= kgemb_pkg::MARGIN_RESET;
            dim_reg    <= kgemb_pkg::DIM_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                kgemb_pkg::REG_LEARNING_RATE: lr_reg     <= pwdata[11:0];
                kgemb_pkg::REG_LOSS_MARGIN:   margin_reg <= pwdata[14:0];
                kgemb_pkg::REG_DIM_IN_USE:    dim_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // In S_DONE the output register is refilled below instead.
            if (out_valid_reg && m_tready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:  if (s_tvalid) state_reg <= S_DISP;
                S_DISP: begin
                    priority case (func_reg)
                        kgemb_pkg::FUNC_READ:  state_reg <= S_RDW;
                        kgemb_pkg::FUNC_TRAIN: state_reg <= S_GATH;
                        default:               state_reg <= S_DONE;
                    endcase
                end
                S_RDW: state_reg <= S_DONE;
                S_GATH: begin
                    if (sub_reg == 3'd4) state_reg <= mode_reg ? S_UR : S_DIST;
                end
                S_DIST: state_reg <= last_el ? S_CHECK : S_GATH;
                S_CHECK: state_reg <= (pm > 25'(neg_reg)) ? S_GATH : S_NRD;
                S_UR:  state_reg <= S_UH;
                S_UH:  state_reg <= S_UT;
                S_UT:  state_reg <= S_UR2;
                S_UR2: state_reg <= S_UNH;
                S_UNH: state_reg <= S_UNT;
                S_UNT: state_reg <= last_el ? S_NRD : S_GATH;
                S_NRD: state_reg <= S_NSQ;
                S_NSQ: state_reg <= last_el ? S_SQRT : S_NRD;
                S_SQRT: begin
                    if (cnt_reg == 5'd18) state_reg <= S_NNEXT;
                end
                S_NNEXT: begin
                    priority if (root_reg > 19'(kgemb_pkg::ONE_Q12) && cnt_reg == 5'd18) begin
                        state_reg <= S_SRD;
                    end else if (nrow_reg == 3'd4) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_NRD;
                    end
                end
                S_SRD:  state_reg <= S_SCAP;
                S_SCAP: state_reg <= S_DIV;
                S_DIV:  if (cnt_reg == 5'd15) state_reg <= S_SWR;
                S_SWR:  state_reg <= last_el ? S_NNEXT : S_SRD;
                S_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                func_reg  <= s_tuser[1:0];
                rdrel_reg <= s_tuser[2];
                h_reg     <= s_tdata[9:0];
                t_reg     <= s_tdata[19:10];
                r_reg     <= s_tdata[25:20];
                nh_reg    <= s_tdata[35:26];
                nt_reg    <= s_tdata[45:36];
                el_in_reg <= s_tdata[52:46];
                wv_reg    <= s_tdata[68:53];
                rv_reg    <= 16'd0;
                pos_reg   <= 24'd0;
                neg_reg   <= 24'd0;
                loss_reg  <= 25'd0;
                upd_reg   <= 1'b0;
                el_reg    <= '0;
                sub_reg   <= 3'd0;
                mode_reg  <= 1'b0;
            end
            S_RDW: rv_reg <= rdrel_reg ? rel_rdata : ent_rdata;
            S_GATH: begin
                sub_reg <= (sub_reg == 3'd4) ? 3'd0 : sub_reg + 3'd1;
                unique case (sub_reg)
                    3'd1: begin vh_reg <= ent_rdata; vr_reg <= rel_rdata; end
                    3'd2: vt_reg  <= ent_rdata;
                    3'd3: vnh_reg <= ent_rdata;
                    3'd4: vnt_reg <= ent_rdata;
                    default: ;
                endcase
            end
            S_DIST: begin
                pos_reg <= pos_reg + 24'(ax1);
                neg_reg <= neg_reg + 24'(ax2);
                el_reg  <= el_reg + 1'b1;
            end
            S_CHECK: begin
                el_reg    <= '0;
                mode_reg  <= 1'b1;
                nrow_reg  <= 3'd0;
                sumsq_reg <= '0;
                if (pm > 25'(neg_reg)) begin
                    loss_reg <= pm - 25'(neg_reg);
                    upd_reg  <= 1'b1;
                end
            end
            S_UR, S_UR2: begin
                vr_reg   <= upd_nv;
                sign_reg <= (state_reg == S_UR) ? (x1 > 18'sd0) : (x2 > 18'sd0);
            end
            S_UH, S_UT, S_UNH, S_UNT: begin
                // Rows that alias the written one see the new value at once.
                if (h_reg == upd_row)  vh_reg  <= upd_nv;
                if (t_reg == upd_row)  vt_reg  <= upd_nv;
                if (nh_reg == upd_row) vnh_reg <= upd_nv;
                if (nt_reg == upd_row) vnt_reg <= upd_nv;
                if (state_reg == S_UNT) begin
                    el_reg    <= last_el ? '0 : el_reg + 1'b1;
                    nrow_reg  <= 3'd0;
                    sumsq_reg <= '0;
                end
            end
            S_NSQ: begin
                sumsq_reg <= sumsq_reg + 38'($unsigned(n_sq));
                el_reg    <= last_el ? '0 : el_reg + 1'b1;
                cnt_reg   <= 5'd0;
                sqrem_reg <= '0;
                root_reg  <= '0;
            end
            S_SQRT: begin
                sumsq_reg <= {sumsq_reg[35:0], 2'b00};
                if (sq_shift >= sq_trial) begin
                    sqrem_reg <= sq_shift - sq_trial;
                    root_reg  <= {root_reg[17:0], 1'b1};
                end else begin
                    sqrem_reg <= sq_shift;
                    root_reg  <= {root_reg[17:0], 1'b0};
                end
                if (cnt_reg != 5'd18) cnt_reg <= cnt_reg + 5'd1;
            end
            S_NNEXT: begin
                el_reg    <= '0;
                sumsq_reg <= '0;
                if (!(root_reg > 19'(kgemb_pkg::ONE_Q12) && cnt_reg == 5'd18)) begin
                    nrow_reg <= nrow_reg + 3'd1;
                end
                cnt_reg <= 5'd0;
            end
            S_SCAP: begin
                // Dividend is magnitude times 4096; its top bits seed the remainder.
                dneg_reg <= n_data[15];
                drem_reg <= 20'(n_mag[15:4]);
                dq_reg   <= {n_mag[3:0], 12'd0};
                cnt_reg  <= 5'd0;
            end
            S_DIV: begin
                if (div_shift >= 20'(root_reg)) begin
                    drem_reg <= div_shift - 20'(root_reg);
                    dq_reg   <= {dq_reg[14:0], 1'b1};
                end else begin
                    drem_reg <= div_shift;
                    dq_reg   <= {dq_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            S_SWR: begin
                el_reg <= last_el ? '0 : el_reg + 1'b1;
                if (last_el) cnt_reg <= 5'd0;
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_reg <= {6'd0, upd_reg, loss_reg, neg_reg, pos_reg, rv_reg};
                end
            end
            default: ;
        endcase
    end

endmodule
